// File: hw/rtl/ilid_pkg.sv
// Shared types and codes for the indexed ordered list.
// No dependencies; imported by the list cells and the top level.
package ilid_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast from the list controller to every cell
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/ilid_cell.sv
// One storage cell of the list row: holds one entry and shifts with its neighbors.
// Depends on ilid_pkg for the broadcast control struct.
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int unsigned AW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  cell_ctrl_t               ctrl,
  input  logic [AW-1:0]            pos,
  input  logic signed [DATA_W-1:0] left_d,
  input  logic signed [DATA_W-1:0] right_d,
  output logic signed [DATA_W-1:0] q
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     above;
  logic                     here;

  assign above = AW'(IDX) > pos;
  assign here  = AW'(IDX) == pos;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (here) begin
        data_nxt = ctrl.value;
      end else if (above) begin
        data_nxt = left_d;
      end
    end else if (ctrl.del) begin
      // close the gap: take the neighbor above
      if (here || above) begin
        data_nxt = right_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

// File: hw/rtl/indexed_list_insert_delete.sv
// Indexed ordered list of up to DEPTH signed 32-bit values held in a row of shifting
// cells. Each transfer is an insert, delete or read at a position; one item is taken
// per clock while the result register is free or being drained. Insert and delete
// shift all cells at or above the position in the same cycle; read selects the cell
// at the clamped position. Depends on ilid_pkg.
module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned OUT_W = ((DATA_W + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // opcode[1:0], position[9:2], value[41:10]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // data_out, count, status (from bit 0 up)
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = (CNT_W > 8) ? CNT_W : 8;

  logic [1:0]               in_opcode;
  logic [7:0]               in_position;
  logic signed [DATA_W-1:0] in_value;

  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]         out_count_r;
  status_t                  out_status_r, out_status_nxt;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            fill_ext;
  logic [AW-1:0]            sel_idx;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  assign in_opcode   = in_tdata[1:0];
  assign in_position = in_tdata[9:2];
  assign in_value    = in_tdata[41:10];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full     = fill_r == CNT_W'(DEPTH);
  assign empty    = fill_r == '0;
  assign pos_ext  = PW'(in_position);
  assign fill_ext = PW'(fill_r);

  // Clamp: insert appends past the end, delete/read stick to the last entry
  always_comb begin
    sel_idx = AW'(in_position);
    if (in_opcode == OP_INSERT) begin
      if (pos_ext > fill_ext) begin
        sel_idx = AW'(fill_r);
      end
    end else if (pos_ext >= fill_ext) begin
      sel_idx = AW'(fill_r - CNT_W'(1));
    end
  end

  always_comb begin
    ctrl.ins       = 1'b0;
    ctrl.del       = 1'b0;
    ctrl.value     = in_value;
    fill_nxt       = fill_r;
    out_data_nxt   = '0;
    out_status_nxt = ST_OK;
    case (in_opcode)
      OP_INSERT: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          ctrl.del     = 1'b1;
          out_data_nxt = cell_q[sel_idx];
          fill_nxt     = fill_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_data_nxt = cell_q[sel_idx];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = cell_q[k];
    end else begin : g_mid_l
      assign left_d = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d = cell_q[k];
    end else begin : g_mid_r
      assign right_d = cell_q[k+1];
    end
    ilid_cell #(
      .AW  (AW),
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .en      (accept),
      .ctrl    (ctrl),
      .pos     (sel_idx),
      .left_d  (left_d),
      .right_d (right_d),
      .q       (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_count_r  <= fill_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_status_r, out_count_r, out_data_r});

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctrl.ins) |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctrl.del) |=> (fill_r == $past(fill_r) - CNT_W'(1)))
    else $error("delete did not shrink the list");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(DEPTH)))
    else $error("full status with list not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> (out_count_r == '0 && out_data_r == '0))
    else $error("empty status with data or entries");

endmodule

// File: bench/testbench.sv
// Self-checking bench for indexed_list_insert_delete: streams insert, delete, read and
// no-op transfers, predicts each result from a local copy of the list and checks it.
// Depends on ilid_pkg and the top level RTL.
`timescale 1ns / 1ps

module testbench;
  import ilid_pkg::*;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_W = ((DATA_W + CNT_W + 2 + 7) / 8) * 8;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int RAND_ITEMS = 1200;
  localparam int PHASE_LEN = 100;
  localparam int PAUSE_AT = 700;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 50;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_LIMIT = 2000;

  // Same order as in_tdata: opcode in the low bits
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  pos;
    logic [1:0]  op;
  } list_op_t;

  // Same order as out_tdata: data_out in the low bits
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic [31:0]      data;
  } list_res_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [47:0]      in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  indexed_list_insert_delete #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  list_op_t    op_q[$];
  list_res_t   want_q[$];
  logic [31:0] list_mem[DEPTH];
  int          list_len = 0;
  int          n_total = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_bad = 0;

  // Apply one operation to the local list and return the result it must produce
  function automatic list_res_t list_apply(list_op_t it);
    list_res_t r;
    int        p;
    r.data   = '0;
    r.status = ST_OK;
    p        = it.pos;
    case (it.op)
      OP_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (p > list_len) p = list_len;
          for (int k = list_len; k > p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p] = it.value;
          list_len++;
        end
      end
      OP_DELETE, OP_READ: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (p >= list_len) p = list_len - 1;
          r.data = list_mem[p];
          if (it.op == OP_DELETE) begin
            for (int k = p; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[CNT_W-1:0];
    return r;
  endfunction

  task automatic note_bad(string what, logic [31:0] want, logic [31:0] got);
    if (n_bad < MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %h, got %h", what, n_got, want, got);
    n_bad++;
  endtask

  function automatic list_op_t mk_op(logic [1:0] op, logic [7:0] pos, logic [31:0] value);
    list_op_t it;
    it.op    = op;
    it.pos   = pos;
    it.value = value;
    return it;
  endfunction

  // Sender: one transfer per item, random gap after each except in the back-to-back runs
  list_op_t cur_op;
  logic     in_fire;
  int       sent_now;
  int       in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      in_fire  = in_tvalid && in_tready;
      sent_now = n_sent + (in_fire ? 1 : 0);
      if (in_fire) begin
        want_q.push_back(list_apply(cur_op));
        n_sent <= sent_now;
        in_gap = ((sent_now / 150) % 4 == 3) ? 0 : $urandom_range(0, 7);
      end
      if (!in_tvalid || in_fire) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (op_q.size() > 0 && !(sent_now == PAUSE_AT && n_got != sent_now)) begin
          cur_op = op_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, cur_op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, stall at random, one long hold-off
  list_res_t got_res;
  list_res_t exp_res;
  int        got_now;
  int        out_gap = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  logic      rdy;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      got_now = n_got;
      if (out_tvalid && out_tready) begin
        got_res = out_tdata[$bits(list_res_t)-1:0];
        if (want_q.size() == 0) begin
          note_bad("unexpected result", '0, got_res.data);
        end else begin
          exp_res = want_q.pop_front();
          if (got_res.data !== exp_res.data) note_bad("data_out", exp_res.data, got_res.data);
          if (got_res.count !== exp_res.count)
            note_bad("count", 32'(exp_res.count), 32'(got_res.count));
          if (got_res.status !== exp_res.status)
            note_bad("status", 32'(exp_res.status), 32'(got_res.status));
        end
        got_now++;
        n_got <= got_now;
        out_gap = ((got_now / 170) % 4 == 1) ? 0 : $urandom_range(0, 7);
      end
      // Hold off long enough for the block to back up into its input
      if (!hold_done && got_now == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  int   pick;
  int   ins_pct;
  logic [1:0]  r_op;
  logic [7:0]  r_pos;
  logic [31:0] r_val;

  initial begin
    // Empty list, no-op, appends and front inserts, clamped reads and deletes
    op_q.push_back(mk_op(OP_READ,   8'd0,   32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd255, 32'h0));
    op_q.push_back(mk_op(OP_NOP,    8'd255, 32'hFFFF_FFFF));
    op_q.push_back(mk_op(OP_INSERT, 8'd255, 32'h7FFF_FFFF));
    op_q.push_back(mk_op(OP_INSERT, 8'd0,   32'h8000_0000));
    op_q.push_back(mk_op(OP_INSERT, 8'd1,   32'h0));
    op_q.push_back(mk_op(OP_INSERT, 8'd200, 32'hFFFF_FFFF));
    op_q.push_back(mk_op(OP_INSERT, 8'd2,   32'h5555_5555));
    op_q.push_back(mk_op(OP_READ,   8'd0,   32'hFFFF_FFFF));
    op_q.push_back(mk_op(OP_READ,   8'd255, 32'h0));
    op_q.push_back(mk_op(OP_READ,   8'd2,   32'h0));
    op_q.push_back(mk_op(OP_NOP,    8'd0,   32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd1,   32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd255, 32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd0,   32'h0));
    op_q.push_back(mk_op(OP_READ,   8'd128, 32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd0,   32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd0,   32'h0));
    op_q.push_back(mk_op(OP_DELETE, 8'd0,   32'h0));
    op_q.push_back(mk_op(OP_READ,   8'd127, 32'h0));
    op_q.push_back(mk_op(OP_INSERT, 8'd128, 32'hAAAA_AAAA));
    op_q.push_back(mk_op(OP_INSERT, 8'd0,   32'h0000_0001));
    // Alternate insert-heavy and delete-heavy runs so the list hits full and empty
    for (int i = 0; i < RAND_ITEMS; i++) begin
      ins_pct = ((i / PHASE_LEN) % 2 == 0) ? 85 : 15;
      pick    = $urandom_range(0, 99);
      if (pick < 3) r_op = OP_NOP;
      else if (pick < 3 + ins_pct) r_op = OP_INSERT;
      else r_op = $urandom_range(0, 1) ? OP_DELETE : OP_READ;
      r_pos = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, DEPTH - 1))
                                           : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 3) r_val = 32'h8000_0000;
      else if (pick < 6) r_val = 32'h7FFF_FFFF;
      else r_val = $urandom;
      op_q.push_back(mk_op(r_op, r_pos, r_val));
    end
    n_total = op_q.size();

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent != n_total || n_got != n_total) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0 && want_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_cell.sv
hw/rtl/indexed_list_insert_delete.sv
bench/testbench.sv
